// ----- rtl/core/bfp_pkg.sv -----
// Shared types and constants for the two-point bearing unit.
`default_nettype none

package bfp_pkg;

  // Coordinate differences are 33-bit signed; the magnitude of either fits 33 bits unsigned.
  localparam int DIFF_W = 33;
  // CORDIC x and y grow by about 1.65 times sqrt(2) over the input magnitude.
  localparam int XY_W = 36;
  // Angle accumulator in units of 2^-32 turn, signed with headroom.
  localparam int Z_W = 34;
  // Angle before rounding: a full turn is 2^32, so one extra bit is kept.
  localparam int ANG_W = 33;
  localparam int TABLE_LEN = 24;
  localparam int DZ_W = 16;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 16'd655;

  localparam logic [ANG_W-1:0] QUARTER_TURN       = 33'h0_4000_0000;
  localparam logic [ANG_W-1:0] HALF_TURN          = 33'h0_8000_0000;
  localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 33'h0_C000_0000;
  localparam logic [ANG_W-1:0] FULL_TURN          = 33'h1_0000_0000;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } bfp_cordic_t;

  // Quadrant and snap information that rides alongside the rotation.
  typedef struct packed {
    logic dead;
    logic dx_neg;
    logic dy_neg;
  } bfp_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/bfp_ifs.sv -----
// Valid/ready channel interfaces for point-pair requests and bearing results.
`default_nettype none

interface bfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_first;
  logic signed [31:0] x_second;
  logic signed [31:0] y_first;
  logic signed [31:0] y_second;

  modport source (output valid, x_first, x_second, y_first, y_second, input ready);
  modport sink   (input valid, x_first, x_second, y_first, y_second, output ready);
endinterface

interface bfp_out_if #(
  parameter int ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] bearing;

  modport source (output valid, bearing, input ready);
  modport sink   (input valid, bearing, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bfp_cordic_stage.sv -----
// One registered CORDIC vectoring iteration with its sideband flags.
`default_nettype none

module bfp_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_valid,
  input  bfp_pkg::bfp_cordic_t in_data,
  input  bfp_pkg::bfp_side_t   in_side,
  output logic                 out_valid,
  output bfp_pkg::bfp_cordic_t out_data,
  output bfp_pkg::bfp_side_t   out_side
);
  import bfp_pkg::*;

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [Z_W-1:0]  step_ang;
  logic                   rot_neg;
  bfp_cordic_t            data_nxt;
  logic                   valid_r;
  bfp_cordic_t            data_r;
  bfp_side_t              side_r;

  always_comb begin
    x_in     = in_data.x;
    y_in     = in_data.y;
    // Arithmetic shifts round toward minus infinity.
    x_sh     = x_in >>> SHIFT;
    y_sh     = y_in >>> SHIFT;
    step_ang = $signed({{(Z_W-32){1'b0}}, ATAN_TAB[SHIFT]});
    rot_neg  = (y_in > 0);
    if (rot_neg) begin
      data_nxt.x = x_in + y_sh;
      data_nxt.y = y_in - x_sh;
      data_nxt.z = in_data.z + step_ang;
    end else begin
      data_nxt.x = x_in - y_sh;
      data_nxt.y = y_in + x_sh;
      data_nxt.z = in_data.z - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ----- rtl/core/bearing_from_two_points_unit.sv -----
// Top level of the pipelined two-point bearing unit.
// Takes two points in signed Q16.16 and returns the clockwise bearing of (x_first - x_second,
// y_first - y_second) from the +y axis as an unsigned binary angle, 2^ANGLE_BITS per turn.
// The pipeline accepts one request every cycle unless a result stalls at the output; each result
// passes through, in order: one stage forms the differences, one takes magnitudes and
// the dead-zone decision, one stage per CORDIC iteration, one places the angle in its
// quadrant, and the output register rounds it. The whole pipeline holds while a result
// waits at the output, so in_bus.ready follows out_bus.ready whenever a result is pending.
// When |dy| is below cfg dead_zone (Q16.16, reset 655), or dy is zero, the bearing snaps to
// a quarter turn for dx >= 0 and three quarters otherwise; write cfg only while idle.
`default_nettype none

module bearing_from_two_points_unit #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  bfp_in_if.sink                      in_bus,
  bfp_out_if.source                   out_bus,
  input  wire                         cfg_we,
  input  wire [bfp_pkg::DZ_W-1:0]     cfg_wdata
);
  import bfp_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(1) << (31 - ANGLE_BITS);

  logic                     en;

  logic [DZ_W-1:0]          dz_r;
  logic signed [DIFF_W-1:0] dz_neg_r;

  logic                     s0_valid_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;

  logic [DIFF_W-1:0]        adx_nxt;
  logic [DIFF_W-1:0]        ady_nxt;
  logic signed [DIFF_W-1:0] dz_pos;
  bfp_side_t                side_nxt;

  logic                     c_valid [NSTEPS+1];
  bfp_cordic_t              c_data  [NSTEPS+1];
  bfp_side_t                c_side  [NSTEPS+1];

  logic signed [Z_W-1:0]    z_fin;
  logic [ANG_W-1:0]         q_clamp;
  logic [ANG_W-1:0]         ang_nxt;
  logic                     ang_valid_r;
  logic [ANG_W-1:0]         ang_r;
  logic [ANG_W-1:0]         rounded;

  logic                     out_valid_r;
  logic [ANGLE_BITS-1:0]    bearing_r;

  // The pipeline advances whenever the output register is empty or being taken.
  assign en           = !out_valid_r || out_bus.ready;
  assign in_bus.ready = en;

  // Dead-zone threshold, kept with its negation for the two-sided compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r     <= DEAD_ZONE_RESET;
      dz_neg_r <= -$signed({{(DIFF_W-DZ_W){1'b0}}, DEAD_ZONE_RESET});
    end else if (cfg_we) begin
      dz_r     <= cfg_wdata;
      dz_neg_r <= -$signed({{(DIFF_W-DZ_W){1'b0}}, cfg_wdata});
    end
  end

  // Stage 0: coordinate differences.
  assign dx_nxt = DIFF_W'(in_bus.x_first) - DIFF_W'(in_bus.x_second);
  assign dy_nxt = DIFF_W'(in_bus.y_first) - DIFF_W'(in_bus.y_second);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // Stage 1: magnitudes, signs and the snap decision.
  always_comb begin
    dz_pos          = $signed({{(DIFF_W-DZ_W){1'b0}}, dz_r});
    adx_nxt         = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    ady_nxt         = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    side_nxt.dx_neg = dx_r[DIFF_W-1];
    side_nxt.dy_neg = dy_r[DIFF_W-1];
    side_nxt.dead   = (dy_r == '0) || ((dy_r < dz_pos) && (dy_r > dz_neg_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_data[0].x <= $signed({{(XY_W-DIFF_W){1'b0}}, ady_nxt});
      c_data[0].y <= $signed({{(XY_W-DIFF_W){1'b0}}, adx_nxt});
      c_data[0].z <= '0;
      c_side[0]   <= side_nxt;
    end
  end

  // CORDIC vectoring, one iteration per stage.
  for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
    bfp_cordic_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (c_valid[k]),
      .in_data   (c_data[k]),
      .in_side   (c_side[k]),
      .out_valid (c_valid[k+1]),
      .out_data  (c_data[k+1]),
      .out_side  (c_side[k+1])
    );
  end

  // Clamp the first-quadrant angle and place it in its quadrant.
  always_comb begin
    z_fin = c_data[NSTEPS].z;
    if (z_fin < 0) begin
      q_clamp = '0;
    end else if (z_fin > $signed({1'b0, QUARTER_TURN})) begin
      q_clamp = QUARTER_TURN;
    end else begin
      q_clamp = ANG_W'(z_fin);
    end

    if (c_side[NSTEPS].dead) begin
      ang_nxt = c_side[NSTEPS].dx_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
    end else if (!c_side[NSTEPS].dy_neg) begin
      ang_nxt = c_side[NSTEPS].dx_neg ? (FULL_TURN - q_clamp) : q_clamp;
    end else begin
      ang_nxt = c_side[NSTEPS].dx_neg ? (HALF_TURN + q_clamp) : (HALF_TURN - q_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_valid_r <= 1'b0;
    end else if (en) begin
      ang_valid_r <= c_valid[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  // Output register: round to the output resolution; a full turn wraps to zero.
  assign rounded = ang_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ang_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing_r <= rounded[31 -: ANGLE_BITS];
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.bearing = bearing_r;

endmodule

`default_nettype wire

// ----- rtl/core/bfp_checker.sv -----
// Port-level checks for the bearing unit and the bind that attaches them.
`default_nettype none

module bfp_checker #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [ANGLE_BITS-1:0] out_bearing
);

  localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int DEPTH  = NSTEPS + 4;
  localparam int CW     = $clog2(DEPTH + 2);

  logic [CW-1:0] pend_r;
  logic [CW-1:0] pend_nxt;

  // Requests accepted whose results have not yet been taken.
  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready) begin
      pend_nxt = pend_nxt + CW'(1);
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bearing))
    else $error("result changed while stalled");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending request");

  a_bounded_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CW'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled while output is free");

endmodule

bind bearing_from_two_points_unit bfp_checker #(
  .ANGLE_BITS   (ANGLE_BITS),
  .CORDIC_STEPS (CORDIC_STEPS)
) u_bfp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_bearing (out_bus.bearing)
);

`default_nettype wire
